// ===== rtl/blqr_pkg.sv =====
`timescale 1ns / 1ps

package blqr_pkg;

  // Wheel count default; the ports always carry a left and a right wheel.
  localparam int WHEEL_COUNT_DEF = 2;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Item kinds carried in the func field.
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_TILT       = 3'd0,
    REG_GAIN_TILT_RATE  = 3'd1,
    REG_GAIN_WHEEL_RATE = 3'd2,
    REG_POWER_LIMIT     = 3'd3,
    REG_STOP_ANGLE      = 3'd4
  } cfg_reg_t;

  localparam logic [23:0] GAIN_TILT_RST       = 24'd789146;
  localparam logic [23:0] GAIN_TILT_RATE_RST  = 24'd85325;
  localparam logic [23:0] GAIN_WHEEL_RATE_RST = 24'd25600;
  localparam logic [7:0]  POWER_LIMIT_RST     = 8'd255;
  localparam logic [14:0] STOP_ANGLE_RST      = 15'd7680;

  // Low-pass coefficients x65536: 0.854 and 0.0728.
  localparam logic [16:0] COEF_KEEP = 17'd55968;
  localparam logic [12:0] COEF_NEW  = 13'd4771;

  // Counts per 10 ms to deg/s x16 is x9600/11 = x872 + x8/11.
  localparam logic [9:0]  RATE_INT    = 10'd872;
  // ceil(2^20 / 11), exact floor division by 11 for the narrow remainder term.
  localparam logic [16:0] RECIP_11    = 17'd95326;
  localparam int          RECIP_SHIFT = 20;
  // Largest |delta| whose rate still fits 24-bit signed.
  localparam logic [15:0] SAT_DELTA   = 16'd9611;

  localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S24_MIN = 24'sh800000;

  typedef struct packed {
    logic [23:0] gain_tilt;
    logic [23:0] gain_tilt_rate;
    logic [23:0] gain_wheel_rate;
    logic [7:0]  power_limit;
    logic [14:0] stop_angle;
  } cfg_t;

  // Classified word handed from front to back.
  typedef struct packed {
    logic        is_tick;
    logic        wheel;
    logic        up;
    logic        trip;
    logic [15:0] angle;
    logic [15:0] rate;
  } cmd_t;

endpackage

// ===== rtl/blqr_front.sv =====
`timescale 1ns / 1ps

module blqr_front #(
  parameter int WHEEL_COUNT = blqr_pkg::WHEEL_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic               wheel,
  input  logic               phase_b,
  input  logic signed [15:0] tilt_angle,
  input  logic signed [15:0] tilt_rate,
  input  logic [14:0]        stop_angle,
  output logic               q_push,
  output blqr_pkg::cmd_t     q_data,
  input  logic               q_full
);
  import blqr_pkg::*;

  logic        slot_valid;
  cmd_t        slot;
  logic        accept;
  logic        keep;
  logic [16:0] angle_ext;
  logic [16:0] angle_mag;
  cmd_t        word;

  assign in_stall = slot_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = slot_valid && !q_full;
  assign q_data   = slot;

  // Tilt magnitude vs. stop threshold; equal does not trip.
  assign angle_ext = {tilt_angle[15], tilt_angle};
  assign angle_mag = angle_ext[16] ? (~angle_ext + 17'd1) : angle_ext;

  // Edges for a wheel that does not exist are dropped here.
  assign keep = (func == FUNC_TICK) || (int'(wheel) < WHEEL_COUNT);

  always_comb begin
    word.is_tick = (func == FUNC_TICK);
    word.wheel   = wheel;
    word.up      = phase_b;
    word.trip    = angle_mag > {2'b00, stop_angle};
    word.angle   = tilt_angle;
    word.rate    = tilt_rate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (accept) begin
      slot_valid <= keep;
    end else if (q_push) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot <= word;
    end
  end

endmodule

// ===== rtl/blqr_queue.sv =====
`timescale 1ns / 1ps

module blqr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  blqr_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output blqr_pkg::cmd_t pop_data
);
  import blqr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= tail + PTR_W'(1);
      end
      if (do_pop) begin
        head <= head + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_data;
    end
  end

endmodule

// ===== rtl/blqr_back.sv =====
`timescale 1ns / 1ps

module blqr_back #(
  parameter int WHEEL_COUNT = blqr_pkg::WHEEL_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  blqr_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  blqr_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     power_left,
  output logic           reverse_left,
  output logic [7:0]     power_right,
  output logic           reverse_right,
  output logic           stopped
);
  import blqr_pkg::*;

  localparam int IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_WHEEL = IDX_W'(WHEEL_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_RAW, ST_RSUM, ST_MNEW, ST_ACC, ST_DONE
  } state_t;

  state_t state;

  // Per-wheel state
  logic [15:0]        encoder_count       [WHEEL_COUNT];
  logic [15:0]        previous_count      [WHEEL_COUNT];
  logic signed [23:0] raw_wheel_rate_prev [WHEEL_COUNT];
  logic signed [23:0] filtered_wheel_rate [WHEEL_COUNT];
  logic               stop_latched;

  // Tick working registers
  logic [IDX_W-1:0]   widx;
  logic signed [15:0] angle;
  logic signed [15:0] rate;
  logic signed [39:0] p_a;
  logic signed [39:0] p_b;
  logic signed [47:0] p_c;
  logic [15:0]        d_mag;
  logic               d_neg;
  logic signed [52:0] s;
  logic [15:0]        frac;
  logic [25:0]        base;
  logic signed [23:0] raw;
  logic signed [41:0] m_keep;
  logic signed [24:0] rs;
  logic signed [38:0] m_new;
  logic [7:0]         res_pw0;
  logic [7:0]         res_pw1;
  logic               res_rev0;
  logic               res_rev1;
  logic               res_stop;

  // Combinational datapath
  logic [IDX_W-1:0]   eidx;
  logic [IDX_W-1:0]   cidx;
  logic [15:0]        cnt_cur;
  logic [15:0]        delta;
  logic [18:0]        y;
  logic [35:0]        y_prod;
  logic [52:0]        s_mag;
  logic [36:0]        pw_full;
  logic [7:0]         pw;
  logic               rev;
  logic [25:0]        mag_sum;
  logic signed [23:0] raw_c;
  logic signed [42:0] acc;
  logic signed [26:0] acc_sh;
  logic signed [23:0] filt_c;

  assign q_pop = (state == ST_IDLE) && q_valid;

  // Single count read port: edge wheel while idle, sequenced wheel otherwise.
  assign eidx    = IDX_W'(q_data.wheel);
  assign cidx    = (state == ST_IDLE) ? eidx : widx;
  assign cnt_cur = encoder_count[cidx];
  assign delta   = cnt_cur - previous_count[widx];

  // round(|d| * 8 / 11) via reciprocal
  assign y      = {d_mag, 3'b000} + 19'd5;
  assign y_prod = 36'(y) * 36'(RECIP_11);

  // Drive magnitude: floor(|s| / 65536), capped
  assign s_mag   = s[52] ? (~s + 53'd1) : s;
  assign pw_full = s_mag[52:16];
  assign pw      = (pw_full > 37'(cfg.power_limit)) ? cfg.power_limit : pw_full[7:0];
  assign rev     = !s[52] && (s != '0);

  assign mag_sum = base + 26'(frac);

  always_comb begin
    if (d_mag > SAT_DELTA) begin
      raw_c = d_neg ? S24_MIN : S24_MAX;
    end else if (d_neg) begin
      raw_c = -$signed(mag_sum[23:0]);
    end else begin
      raw_c = $signed(mag_sum[23:0]);
    end
  end

  // Low-pass: floor((keep + new + 0.5) / 65536), saturated
  assign acc    = 43'(m_keep) + 43'(m_new) + 43'sd32768;
  assign acc_sh = 27'(acc >>> 16);

  always_comb begin
    if (acc_sh > 27'sd8388607) begin
      filt_c = S24_MAX;
    end else if (acc_sh < -27'sd8388608) begin
      filt_c = S24_MIN;
    end else begin
      filt_c = acc_sh[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stop_latched <= 1'b0;
      out_valid    <= 1'b0;
      widx         <= '0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        encoder_count[i]       <= '0;
        previous_count[i]      <= '0;
        raw_wheel_rate_prev[i] <= '0;
        filtered_wheel_rate[i] <= '0;
      end
    end else begin
      // ST_DONE owns out_valid while it hands a word over
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (!q_data.is_tick) begin
              encoder_count[eidx] <= q_data.up ? (cnt_cur + 16'd1) : (cnt_cur - 16'd1);
            end else begin
              res_pw0  <= '0;
              res_pw1  <= '0;
              res_rev0 <= 1'b0;
              res_rev1 <= 1'b0;
              if (q_data.trip || stop_latched) begin
                // Stopped tick: zero drive, wheel rate state frozen.
                stop_latched <= 1'b1;
                res_stop     <= 1'b1;
                state        <= ST_DONE;
              end else begin
                res_stop <= 1'b0;
                angle    <= $signed(q_data.angle);
                rate     <= $signed(q_data.rate);
                widx     <= '0;
                state    <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          p_a   <= $signed(cfg.gain_tilt) * angle;
          p_b   <= $signed(cfg.gain_tilt_rate) * rate;
          p_c   <= $signed(cfg.gain_wheel_rate) * filtered_wheel_rate[widx];
          d_neg <= delta[15];
          d_mag <= delta[15] ? (~delta + 16'd1) : delta;
          previous_count[widx] <= cnt_cur;
          state <= ST_SUM;
        end
        ST_SUM: begin
          s     <= 53'(p_a) + (53'(p_b) <<< 4) + (53'(p_c) <<< 4);
          frac  <= 16'(y_prod >> RECIP_SHIFT);
          base  <= 26'(d_mag) * 26'(RATE_INT);
          state <= ST_RAW;
        end
        ST_RAW: begin
          if (widx == IDX_W'(0)) begin
            res_pw0  <= pw;
            res_rev0 <= rev;
          end
          if (WHEEL_COUNT > 1 && widx == IDX_W'(1)) begin
            res_pw1  <= pw;
            res_rev1 <= rev;
          end
          raw    <= raw_c;
          m_keep <= $signed({1'b0, COEF_KEEP}) * filtered_wheel_rate[widx];
          state  <= ST_RSUM;
        end
        ST_RSUM: begin
          rs                        <= 25'(raw) + 25'(raw_wheel_rate_prev[widx]);
          raw_wheel_rate_prev[widx] <= raw;
          state                     <= ST_MNEW;
        end
        ST_MNEW: begin
          m_new <= rs * $signed({1'b0, COEF_NEW});
          state <= ST_ACC;
        end
        ST_ACC: begin
          filtered_wheel_rate[widx] <= filt_c;
          if (widx == LAST_WHEEL) begin
            state <= ST_DONE;
          end else begin
            widx  <= widx + IDX_W'(1);
            state <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            power_left    <= res_pw0;
            reverse_left  <= res_rev0;
            power_right   <= res_pw1;
            reverse_right <= res_rev1;
            stopped       <= res_stop;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/balance_lqr_drive_controller_unit.sv =====
`timescale 1ns / 1ps

// Balance drive controller: state feedback for a two-wheel balancing robot.
// Input channel (in_valid / in_stall): one word per encoder edge (func 0,
// wheel, phase_b) or per control tick (func 1, tilt_angle, tilt_rate).
// Output channel (out_valid / out_stall): one word per tick with power and
// reverse for each wheel plus the stopped flag; edges give no output word.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): gains, power
// limit, stop angle; cfg_ready is always high, write only while idle.
// Timing: a front stage classifies each word into a 4-entry queue; the back
// sequencer handles an edge in its idle state, and a tick in MUL, SUM, RAW,
// RSUM, MNEW and ACC for each wheel in turn, then DONE: the per-wheel
// multiply / filter sequence. A tick that stops goes from idle to DONE.
// A driving tick passes the front slot, then the queue, then the sequence.
// If out_stall holds a result, the back waits with the next one finished,
// while the queue keeps taking words until full, then in_stall rises.
// Reset (rst, synchronous) clears counts, filters, the stop latch and the
// queue, and reloads the register defaults. The stop latch clears only on
// reset.
module balance_lqr_drive_controller_unit #(
  parameter int WHEEL_COUNT = blqr_pkg::WHEEL_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic                             wheel,
  input  logic                             phase_b,
  input  logic signed [15:0]               tilt_angle,
  input  logic signed [15:0]               tilt_rate,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       power_left,
  output logic                             reverse_left,
  output logic [7:0]                       power_right,
  output logic                             reverse_right,
  output logic                             stopped,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [blqr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blqr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import blqr_pkg::*;

  cfg_t cfg;
  cmd_t push_data;
  cmd_t pop_data;
  logic push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  // Register file; indexes past the stop angle are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_tilt       <= GAIN_TILT_RST;
      cfg.gain_tilt_rate  <= GAIN_TILT_RATE_RST;
      cfg.gain_wheel_rate <= GAIN_WHEEL_RATE_RST;
      cfg.power_limit     <= POWER_LIMIT_RST;
      cfg.stop_angle      <= STOP_ANGLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_TILT:       cfg.gain_tilt       <= cfg_data;
        REG_GAIN_TILT_RATE:  cfg.gain_tilt_rate  <= cfg_data;
        REG_GAIN_WHEEL_RATE: cfg.gain_wheel_rate <= cfg_data;
        REG_POWER_LIMIT:     cfg.power_limit     <= cfg_data[7:0];
        REG_STOP_ANGLE:      cfg.stop_angle      <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept, classify stop trip, drop edges of absent wheels.
  blqr_front #(
    .WHEEL_COUNT(WHEEL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .wheel      (wheel),
    .phase_b    (phase_b),
    .tilt_angle (tilt_angle),
    .tilt_rate  (tilt_rate),
    .stop_angle (cfg.stop_angle),
    .q_push     (push),
    .q_data     (push_data),
    .q_full     (q_full)
  );

  // Words between front and back, in order.
  blqr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (pop_data)
  );

  // Back: counts edges, runs the per-wheel feedback and filter sequence.
  blqr_back #(
    .WHEEL_COUNT(WHEEL_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_data        (pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .power_left    (power_left),
    .reverse_left  (reverse_left),
    .power_right   (power_right),
    .reverse_right (reverse_right),
    .stopped       (stopped)
  );

endmodule

// ===== bench/balance_lqr_drive_controller_unit_tb.sv =====
`timescale 1ns / 1ps

module balance_lqr_drive_controller_unit_tb;
  import blqr_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_TICKS = 8;
  // Back end runs a per-wheel sequence per tick plus a 4-deep queue; SETTLE
  // covers any edge words still in flight after the last drive word.
  localparam int SETTLE      = 40;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_REPORTS = 40;
  localparam int WHEELS      = 2;

  // Encoder B phase meaning.
  localparam logic PHASE_UP   = 1'b1;
  localparam logic PHASE_DOWN = 1'b0;

  // Indexes past the last register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Rate scaling as 9600/11; low-pass in fixed point x65536.
  localparam longint RATE_MUL   = 9600;
  localparam longint RATE_DIV   = 11;
  localparam longint KEEP_Q16   = 55968;
  localparam longint BLEND_Q16  = 4771;
  localparam longint ROUND_Q16  = 32768;
  localparam longint LIM24_HI   = 8388607;
  localparam longint LIM24_LO   = -8388608;

  // One drive word as the block hands it out.
  typedef struct packed {
    logic [7:0] power_left;
    logic       reverse_left;
    logic [7:0] power_right;
    logic       reverse_right;
    logic       stopped;
  } drive_word_t;

  logic clk = 1'b0;
  logic rst;

  logic                  in_valid;
  logic                  in_stall;
  logic                  func;
  logic                  wheel;
  logic                  phase_b;
  logic signed [15:0]    tilt_angle;
  logic signed [15:0]    tilt_rate;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            power_left;
  logic                  reverse_left;
  logic [7:0]            power_right;
  logic                  reverse_right;
  logic                  stopped;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Controller shadow: registers, encoder/filter state, stop latch.
  logic [23:0] k_tilt;
  logic [23:0] k_tilt_rate;
  logic [23:0] k_wheel;
  logic [7:0]  power_cap;
  logic [14:0] stop_lim;
  logic [15:0] enc_cnt   [WHEELS];
  logic [15:0] prev_cnt  [WHEELS];
  longint      raw_prev  [WHEELS];
  longint      filt_rate [WHEELS];
  bit          stop_hold;

  drive_word_t drive_words_due[$];

  // No idling on either side once set.
  bit quiet;

  int edge_words;
  int tick_words;
  int halted_ticks;
  int words_checked;
  int bad_words;
  int settings_applied;
  int idle_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  balance_lqr_drive_controller_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .wheel         (wheel),
    .phase_b       (phase_b),
    .tilt_angle    (tilt_angle),
    .tilt_rate     (tilt_rate),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .power_left    (power_left),
    .reverse_left  (reverse_left),
    .power_right   (power_right),
    .reverse_right (reverse_right),
    .stopped       (stopped),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic longint clamp_s24(input longint v);
    if (v > LIM24_HI) return LIM24_HI;
    if (v < LIM24_LO) return LIM24_LO;
    return v;
  endfunction

  // Feedback sum s = -u * 65536; power is floor(|u|) capped, reverse when u < 0.
  function automatic void wheel_drive(input int k, input longint ang, input longint rt,
                                      output logic [7:0] pwr, output logic rev);
    longint s;
    longint mag;
    longint p;
    s = longint'($signed(k_tilt)) * ang
      + longint'($signed(k_tilt_rate)) * rt * 16
      + longint'($signed(k_wheel)) * filt_rate[k] * 16;
    mag = (s < 0) ? -s : s;
    p = mag >>> 16;
    if (p > longint'(power_cap)) p = longint'(power_cap);
    pwr = p[7:0];
    rev = (s > 0);
  endfunction

  // Advance the shadow by one accepted word; returns 1 when a drive word is due.
  function automatic bit predict_drive(input logic f, input logic w, input logic pb,
                                       input logic [15:0] ang, input logic [15:0] rt,
                                       output drive_word_t dw);
    longint a;
    longint r;
    longint a_mag;
    longint delta;
    longint n;
    longint raw;
    longint acc;
    logic [15:0] d16;
    int k;
    dw = '0;
    if (f == FUNC_EDGE) begin
      if (pb == PHASE_UP) enc_cnt[w] = enc_cnt[w] + 16'd1;
      else enc_cnt[w] = enc_cnt[w] - 16'd1;
      return 1'b0;
    end
    a = longint'($signed(ang));
    r = longint'($signed(rt));
    a_mag = (a < 0) ? -a : a;
    // |angle| equal to the limit is still allowed
    if (a_mag > longint'(stop_lim)) stop_hold = 1'b1;
    if (stop_hold) begin
      dw.stopped = 1'b1;
      halted_ticks++;
      return 1'b1;
    end
    // drive uses the filtered rate from the previous tick
    wheel_drive(0, a, r, dw.power_left, dw.reverse_left);
    wheel_drive(1, a, r, dw.power_right, dw.reverse_right);
    for (k = 0; k < WHEELS; k++) begin
      d16 = enc_cnt[k] - prev_cnt[k];
      delta = longint'($signed(d16));
      prev_cnt[k] = enc_cnt[k];
      n = delta * RATE_MUL;
      raw = (n >= 0) ? (n + RATE_DIV / 2) / RATE_DIV : -((-n + RATE_DIV / 2) / RATE_DIV);
      raw = clamp_s24(raw);
      acc = KEEP_Q16 * filt_rate[k] + BLEND_Q16 * (raw + raw_prev[k]) + ROUND_Q16;
      filt_rate[k] = clamp_s24(acc >>> 16);
      raw_prev[k] = raw;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Output side: random stall bursts, with calm stretches in between
  // ---------------------------------------------------------------------

  initial begin
    int hold;
    int calm;
    hold = 0;
    calm = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else begin
        out_stall = 1'b0;
        if (calm > 0) begin
          calm--;
        end else if (!quiet) begin
          if ($urandom_range(0, 39) == 0) calm = $urandom_range(30, 150);
          else if ($urandom_range(0, 5) == 0) hold = $urandom_range(1, 12);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checking: each accepted drive word against the oldest prediction
  // ---------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      bad_words++;
      if (bad_words <= MAX_REPORTS)
        $display("%0t: drive word %0d %s expected %0d actual %0d",
                 $time, words_checked, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    drive_word_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (drive_words_due.size() == 0) begin
        bad_words++;
        $display("%0t: drive word with nothing predicted, expected none actual %0d/%0d %0d/%0d %0d",
                 $time, power_left, reverse_left, power_right, reverse_right, stopped);
      end else begin
        want = drive_words_due.pop_front();
        check_field("power_left", want.power_left, power_left);
        check_field("reverse_left", {7'd0, want.reverse_left}, {7'd0, reverse_left});
        check_field("power_right", want.power_right, power_right);
        check_field("reverse_right", {7'd0, want.reverse_right}, {7'd0, reverse_right});
        check_field("stopped", {7'd0, want.stopped}, {7'd0, stopped});
        words_checked++;
      end
    end
  end

  // Watchdog: too long without any handshake on any channel ends the run.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
                 || (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d drive words outstanding",
                 $time, IDLE_LIMIT, drive_words_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------

  int send_calm;

  // One input word; held until accepted, then the shadow is advanced.
  task automatic send_word(input logic f, input logic w, input logic pb,
                           input logic [15:0] ang, input logic [15:0] rt);
    drive_word_t dw;
    @(negedge clk);
    if (send_calm > 0) begin
      send_calm--;
    end else if (!quiet) begin
      if ($urandom_range(0, 49) == 0) begin
        send_calm = $urandom_range(20, 120);
      end else if ($urandom_range(0, 5) == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    in_valid   = 1'b1;
    func       = f;
    wheel      = w;
    phase_b    = pb;
    tilt_angle = ang;
    tilt_rate  = rt;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (f == FUNC_EDGE) edge_words++;
    else tick_words++;
    if (predict_drive(f, w, pb, ang, rt, dw)) drive_words_due.push_back(dw);
  endtask

  task automatic send_edge(input logic w, input logic pb);
    send_word(FUNC_EDGE, w, pb, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_tick(input logic [15:0] ang, input logic [15:0] rt);
    send_word(FUNC_TICK, 1'($urandom), 1'($urandom), ang, rt);
  endtask

  // Sender stops until every predicted drive word has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (drive_words_due.size() != 0) @(posedge clk);
  endtask

  // Block idle: nothing owed, and trailing edge words worked off.
  task automatic wait_idle();
    drain_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_GAIN_TILT:       k_tilt      = data;
      REG_GAIN_TILT_RATE:  k_tilt_rate = data;
      REG_GAIN_WHEEL_RATE: k_wheel     = data;
      REG_POWER_LIMIT:     power_cap   = data[7:0];
      REG_STOP_ANGLE:      stop_lim    = data[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Full register set; upper junk bits on the narrow registers must be dropped.
  task automatic apply_settings(input logic [23:0] gt, input logic [23:0] gtr,
                                input logic [23:0] gw, input logic [7:0] plim,
                                input logic [14:0] stop);
    wait_idle();
    write_reg(REG_GAIN_TILT, gt);
    write_reg(REG_GAIN_TILT_RATE, gtr);
    write_reg(REG_GAIN_WHEEL_RATE, gw);
    write_reg(REG_POWER_LIMIT, {16'($urandom), plim});
    write_reg(REG_STOP_ANGLE, {9'($urandom), stop});
    write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 24'($urandom));
    settings_applied++;
  endtask

  function automatic logic [15:0] pick_angle(input int lim);
    int a;
    case ($urandom_range(0, 3))
      0: a = $urandom_range(0, 1) ? lim : -lim;
      1: a = int'($urandom_range(0, 128)) - 64;
      default: a = int'($urandom_range(0, 2 * lim)) - lim;
    endcase
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a[15:0];
  endfunction

  function automatic logic [15:0] pick_rate();
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1: v = 16'(int'($urandom_range(0, 400)) - 200);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset registers: zero command, both wheels both directions, count wrap
  // below zero, angle exactly at the stop limit, rate extremes.
  task automatic test_directed_corners();
    int k;
    send_tick(16'sd0, 16'sd0);
    for (k = 0; k < 3; k++) send_edge(1'b0, PHASE_UP);
    for (k = 0; k < 2; k++) send_edge(1'b1, PHASE_DOWN);
    send_tick(16'sd7680, 16'sh7FFF);
    send_tick(-16'sd7680, 16'sh8000);
    send_edge(1'b0, PHASE_DOWN);
    send_edge(1'b1, PHASE_UP);
    send_tick(16'sd1, -16'sd1);
    send_tick(-16'sd1, 16'sd0);
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd256, 16'sd16);
    send_tick(16'sd0, 16'sd0);
  endtask

  // Long one-way runs between two ticks give a large wheel rate step,
  // one wheel each way, then the filter settles over a few ticks.
  task automatic test_encoder_overrun();
    int k;
    for (k = 0; k < 120; k++) send_edge(1'b0, PHASE_UP);
    for (k = 0; k < 120; k++) send_edge(1'b1, PHASE_DOWN);
    send_tick(16'sd0, 16'sd0);
    for (k = 0; k < 4; k++) send_tick(pick_angle(int'(stop_lim)), pick_rate());
  endtask

  // Runs of encoder words, mostly one way on one wheel, then a tick.
  task automatic test_random_traffic(input int n_words, input bit pause_midway);
    int sent;
    int run;
    int k;
    logic w;
    logic dir;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < n_words) begin
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      w   = 1'($urandom_range(0, 1));
      dir = 1'($urandom_range(0, 1));
      for (k = 0; k < run; k++) begin
        if ($urandom_range(0, 7) == 0) send_edge(~w, 1'($urandom_range(0, 1)));
        else send_edge(w, ($urandom_range(0, 5) == 0) ? ~dir : dir);
      end
      send_tick(pick_angle(int'(stop_lim)), pick_rate());
      sent += run + 1;
      if (pause_midway && !paused && sent >= n_words / 2) begin
        drain_results();
        paused = 1;
      end
    end
  endtask

  // Register extremes, a couple of random sets, then back to the defaults.
  task automatic test_config_sweep();
    apply_settings(S24_MAX, S24_MIN, 24'd0, 8'd255, 15'h7FFF);
    test_random_traffic(270, 1'b0);
    // stop limit 0: only a level robot keeps driving
    apply_settings(S24_MIN, S24_MAX, S24_MAX, 8'd0, 15'd0);
    test_random_traffic(270, 1'b0);
    apply_settings(24'(int'($urandom_range(0, 8191)) - 4096),
                   24'(int'($urandom_range(0, 8191)) - 4096),
                   24'(int'($urandom_range(0, 127)) - 64),
                   8'($urandom_range(1, 254)), 15'($urandom_range(1, 32766)));
    test_random_traffic(270, 1'b1);
    apply_settings(24'd0, 24'd0, 24'(int'($urandom_range(0, 63)) - 32), 8'd255, 15'd16000);
    test_random_traffic(270, 1'b0);
    quiet = 1'b1;
    apply_settings(GAIN_TILT_RST, GAIN_TILT_RATE_RST, GAIN_WHEEL_RATE_RST,
                   POWER_LIMIT_RST, STOP_ANGLE_RST);
    test_random_traffic(270, 1'b0);
  endtask

  // Latch is permanent, so this goes last: full-scale limit, then the one
  // angle beyond it; edges keep counting while stopped.
  task automatic test_stop_latch();
    int k;
    wait_idle();
    write_reg(REG_STOP_ANGLE, 24'h007FFF);
    send_tick(16'sh7FFF, pick_rate());
    send_edge(1'b0, PHASE_UP);
    send_tick(16'sh8000, pick_rate());
    for (k = 0; k < 40; k++) begin
      if ($urandom_range(0, 1)) send_edge(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else send_tick(pick_angle(32767), pick_rate());
    end
    send_tick(16'sd0, 16'sd0);
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    int k;
    rst        = 1'b1;
    in_valid   = 1'b0;
    func       = FUNC_EDGE;
    wheel      = 1'b0;
    phase_b    = PHASE_DOWN;
    tilt_angle = '0;
    tilt_rate  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_GAIN_TILT;
    cfg_data   = '0;
    quiet      = 1'b0;
    send_calm  = 0;
    edge_words = 0;
    tick_words = 0;
    halted_ticks = 0;
    words_checked = 0;
    bad_words = 0;
    settings_applied = 0;

    k_tilt      = GAIN_TILT_RST;
    k_tilt_rate = GAIN_TILT_RATE_RST;
    k_wheel     = GAIN_WHEEL_RATE_RST;
    power_cap   = POWER_LIMIT_RST;
    stop_lim    = STOP_ANGLE_RST;
    for (k = 0; k < WHEELS; k++) begin
      enc_cnt[k]   = '0;
      prev_cnt[k]  = '0;
      raw_prev[k]  = 0;
      filt_rate[k] = 0;
    end
    stop_hold = 1'b0;

    repeat (RESET_TICKS) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_corners();
    test_encoder_overrun();
    test_config_sweep();
    test_stop_latch();

    wait_idle();
    $display("Covered %0d encoder words and %0d ticks (%0d while stopped) over %0d settings;",
             edge_words, tick_words, halted_ticks, settings_applied);
    $display("%0d drive words checked, %0d field mismatches.", words_checked, bad_words);
    if (bad_words == 0 && drive_words_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
